### rtl/tts_pkg.sv
package tts_pkg;

  localparam logic [3:0] OP_TICK        = 4'd0;
  localparam logic [3:0] OP_INIT        = 4'd1;
  localparam logic [3:0] OP_DISABLE     = 4'd2;
  localparam logic [3:0] OP_SET_PENDING = 4'd3;
  localparam logic [3:0] OP_SET_DELAY   = 4'd4;
  localparam logic [3:0] OP_SET_PERIOD  = 4'd5;
  localparam logic [3:0] OP_RESET_TIMER = 4'd6;
  localparam logic [3:0] OP_DISPATCH    = 4'd7;
  localparam logic [3:0] OP_COMPLETE    = 4'd8;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_ALREADY = 2'd1;
  localparam logic [1:0] STAT_NOT_EN  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_TICK
  } state_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [2:0]  task_req;
    logic [31:0] value;
    logic        task_failed;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        dispatch_valid;
    logic [2:0]  dispatch_task;
    logic [31:0] system_time;
  } res_t;

endpackage

### rtl/tick_task_scheduler.sv
// Tick-driven periodic task scheduler.
// Commands enter on cmd_i with start; a command is taken at a rising edge
// where start is high and busy is low. Each command gives exactly one result
// on res_o, marked by done_o for a single cycle; the receiver cannot stall.
// Period and countdown of every slot sit in two RAMs with registered reads;
// enable and pending flags are flip-flops.
// Command flow:
//   - tick: busy while the walker reads, decrements and writes back one slot
//     per cycle (RAM read pipelined one slot ahead); done_o rises as busy
//     falls, after the last slot has been written back.
//   - other commands: busy while the addressed slot is read from RAM (ST_CMD);
//     done_o rises as busy falls.
// No new command is taken while busy is high.
// A new command may be taken in the cycle where done_o is high.
// Reset clears all enable and pending flags and the system time; slot RAM
// contents are not cleared and are only used once init has written them.
module tick_task_scheduler
  import tts_pkg::*;
#(
  parameter int TASK_COUNT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output res_t res_o,
  output logic done_o
);

  localparam int AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int RamDepth = (TASK_COUNT > 1) ? TASK_COUNT : 2;

  state_e              state_q, state_d;
  cmd_t                cmd_q, cmd_d;
  logic [AW-1:0]       walk_q, walk_d;
  logic [TASK_COUNT-1:0] en_q, en_d;
  logic [TASK_COUNT-1:0] pend_q, pend_d;
  logic [31:0]         time_q, time_d;
  res_t                res_q, res_d;
  logic                done_q, done_d;

  logic                accept;
  logic [31:0]         in_req_ext, q_req_ext;
  logic [AW-1:0]       in_addr, q_addr;
  logic                q_in_range, q_enabled;

  logic [AW-1:0]       raddr;
  logic                per_we, cd_we;
  logic [AW-1:0]       waddr;
  logic [31:0]         per_wdata, cd_wdata;
  logic [31:0]         per_rdata, cd_rdata;
  logic [31:0]         cd_dec;

  logic [TASK_COUNT-1:0] ready_set;
  logic                disp_hit;
  logic [AW-1:0]       disp_sel;

  assign accept     = start && !busy;
  assign in_req_ext = 32'(cmd_i.task_req);
  assign in_addr    = in_req_ext[AW-1:0];
  assign q_req_ext  = 32'(cmd_q.task_req);
  assign q_addr     = q_req_ext[AW-1:0];
  assign q_in_range = q_req_ext < 32'(TASK_COUNT);
  assign q_enabled  = q_in_range && en_q[q_addr];
  assign cd_dec     = cd_rdata - 32'd1;

  // Lowest enabled pending slot.
  assign ready_set = en_q & pend_q;
  always_comb begin
    disp_hit = 1'b0;
    disp_sel = '0;
    for (int i = TASK_COUNT - 1; i >= 0; i--) begin
      if (ready_set[i]) begin
        disp_hit = 1'b1;
        disp_sel = AW'(i);
      end
    end
  end

  tts_ram #(.Width(32), .Depth(RamDepth)) u_period_ram (
    .clk_i   (clk_i),
    .we_i    (per_we),
    .waddr_i (waddr),
    .wdata_i (per_wdata),
    .raddr_i (raddr),
    .rdata_o (per_rdata)
  );

  tts_ram #(.Width(32), .Depth(RamDepth)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cd_we),
    .waddr_i (waddr),
    .wdata_i (cd_wdata),
    .raddr_i (raddr),
    .rdata_o (cd_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    walk_d    = walk_q;
    en_d      = en_q;
    pend_d    = pend_q;
    time_d    = time_q;
    res_d     = res_q;
    done_d    = 1'b0;
    raddr     = '0;
    per_we    = 1'b0;
    cd_we     = 1'b0;
    waddr     = q_addr;
    per_wdata = cmd_q.value;
    cd_wdata  = cmd_q.value;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          walk_d = '0;
          if (cmd_i.opcode == OP_TICK) begin
            raddr   = '0;
            state_d = ST_TICK;
          end else begin
            raddr   = in_addr;
            state_d = ST_CMD;
          end
        end
      end

      ST_TICK: begin
        // Read one slot ahead; write back the slot whose data is here.
        raddr    = walk_q + AW'(1);
        waddr    = walk_q;
        cd_wdata = cd_dec;
        if (en_q[walk_q] && (per_rdata != '0 || cd_rdata != '0)) begin
          cd_we = 1'b1;
          if (cd_dec == '0) begin
            pend_d[walk_q] = 1'b1;
          end
        end
        walk_d = walk_q + AW'(1);
        if (walk_q == AW'(TASK_COUNT - 1)) begin
          time_d                   = time_q + 32'd1;
          res_d.status             = STAT_OK;
          res_d.dispatch_valid     = 1'b0;
          res_d.dispatch_task      = '0;
          res_d.system_time        = time_q + 32'd1;
          done_d                   = 1'b1;
          state_d                  = ST_IDLE;
        end
      end

      ST_CMD: begin
        res_d.status         = STAT_OK;
        res_d.dispatch_valid = 1'b0;
        res_d.dispatch_task  = '0;
        res_d.system_time    = time_q;
        done_d               = 1'b1;
        state_d              = ST_IDLE;
        priority if (cmd_q.opcode == OP_INIT) begin
          if (!q_in_range) begin
            res_d.status = STAT_NOT_EN;
          end else begin
            if (en_q[q_addr]) begin
              res_d.status = STAT_ALREADY;
            end
            per_we         = 1'b1;
            cd_we          = 1'b1;
            pend_d[q_addr] = 1'b0;
            en_d[q_addr]   = 1'b1;
          end
        end else if (cmd_q.opcode == OP_DISPATCH) begin
          if (disp_hit) begin
            pend_d[disp_sel]     = 1'b0;
            res_d.dispatch_valid = 1'b1;
            res_d.dispatch_task  = 3'(disp_sel);
          end
        end else if (cmd_q.opcode >= OP_DISABLE && cmd_q.opcode <= OP_COMPLETE) begin
          if (!q_enabled) begin
            res_d.status = STAT_NOT_EN;
          end else begin
            unique case (cmd_q.opcode)
              OP_DISABLE:     en_d[q_addr] = 1'b0;
              OP_SET_PENDING: pend_d[q_addr] = 1'b1;
              OP_SET_DELAY:   cd_we = 1'b1;
              OP_SET_PERIOD:  per_we = 1'b1;
              OP_RESET_TIMER: begin
                cd_we    = 1'b1;
                cd_wdata = per_rdata;
              end
              default: begin
                if (cmd_q.task_failed) begin
                  en_d[q_addr] = 1'b0;
                end
                if (per_rdata != '0) begin
                  cd_we    = 1'b1;
                  cd_wdata = per_rdata;
                end
              end
            endcase
          end
        end else begin
          // Unused opcodes: answer ok, change nothing.
          res_d.status = STAT_OK;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      walk_q  <= '0;
      en_q    <= '0;
      pend_q  <= '0;
      time_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      en_q    <= en_d;
      pend_q  <= pend_d;
      time_q  <= time_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign res_o  = res_q;
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not raise busy");

  a_ram_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (per_we || cd_we) |-> busy)
    else $error("slot RAM written while idle");

  a_dispatch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.dispatch_valid) |-> (res_o.status == STAT_OK))
    else $error("dispatch result with error status");

endmodule

### rtl/tts_ram.sv
module tts_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### test/testbench.sv
module testbench;
  import tts_pkg::*;

  localparam int          TASK_COUNT   = 8;
  localparam int          RANDOM_ITEMS = 850;
  localparam logic [3:0]  OP_RESERVED  = 4'd15;

  typedef struct {
    cmd_t cmd;
    logic typed;
    res_t res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  res_t res_o;
  logic done_o;

  // scheduler state as seen by the predictor
  logic [TASK_COUNT-1:0] en_mask;
  logic [TASK_COUNT-1:0] pend_mask;
  logic [31:0]           period_mem [TASK_COUNT];
  logic [31:0]           count_mem  [TASK_COUNT];
  logic [31:0]           sys_time;

  stim_row_t directed_rows [$];
  res_t      expected_results [$];
  res_t      want;
  int        idle_pct;
  int        mismatch_count = 0;

  tick_task_scheduler #(
    .TASK_COUNT(TASK_COUNT)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .cmd_i (cmd_i),
    .busy  (busy),
    .res_o (res_o),
    .done_o(done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic res_t schedule_step(cmd_t c);
    res_t        r;
    logic        found;
    logic [2:0]  s;
    r     = '0;
    found = 1'b0;
    s     = c.task_req;
    case (c.opcode)
      OP_TICK: begin
        sys_time = sys_time + 32'd1;
        for (int i = 0; i < TASK_COUNT; i++) begin
          if (en_mask[i] && (period_mem[i] != '0 || count_mem[i] != '0)) begin
            count_mem[i] = count_mem[i] - 32'd1;
            if (count_mem[i] == '0) pend_mask[i] = 1'b1;
          end
        end
      end
      OP_INIT: begin
        if (en_mask[s]) r.status = STAT_ALREADY;
        period_mem[s] = c.value;
        count_mem[s]  = c.value;
        pend_mask[s]  = 1'b0;
        en_mask[s]    = 1'b1;
      end
      OP_DISPATCH: begin
        for (int i = 0; i < TASK_COUNT; i++) begin
          if (!found && en_mask[i] && pend_mask[i]) begin
            found            = 1'b1;
            pend_mask[i]     = 1'b0;
            r.dispatch_valid = 1'b1;
            r.dispatch_task  = 3'(i);
          end
        end
      end
      OP_DISABLE, OP_SET_PENDING, OP_SET_DELAY, OP_SET_PERIOD,
      OP_RESET_TIMER, OP_COMPLETE: begin
        if (!en_mask[s]) begin
          r.status = STAT_NOT_EN;
        end else begin
          case (c.opcode)
            OP_DISABLE:     en_mask[s]    = 1'b0;
            OP_SET_PENDING: pend_mask[s]  = 1'b1;
            OP_SET_DELAY:   count_mem[s]  = c.value;
            OP_SET_PERIOD:  period_mem[s] = c.value;
            OP_RESET_TIMER: count_mem[s]  = period_mem[s];
            default: begin
              if (c.task_failed) en_mask[s] = 1'b0;
              if (period_mem[s] != '0) count_mem[s] = period_mem[s];
            end
          endcase
        end
      end
      default: ;
    endcase
    r.system_time = sys_time;
    return r;
  endfunction

  task automatic add_row(logic [3:0] op, logic [2:0] slot, logic [31:0] val,
                         logic failed, logic typed, logic [1:0] st, logic [31:0] t);
    stim_row_t row;
    row.cmd.opcode      = op;
    row.cmd.task_req    = slot;
    row.cmd.value       = val;
    row.cmd.task_failed = failed;
    row.typed           = typed;
    row.res             = '0;
    row.res.status      = st;
    row.res.system_time = t;
    directed_rows.push_back(row);
  endtask

  // drive one command and hold it until the transfer
  task automatic send(cmd_t c, logic typed, res_t typed_res);
    res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = schedule_step(c);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, res_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_o.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, res_o.status);
          mismatch_count++;
        end
        if (res_o.dispatch_valid !== want.dispatch_valid) begin
          $display("%0t: dispatch_valid expected %0b, actual %0b", $time,
                   want.dispatch_valid, res_o.dispatch_valid);
          mismatch_count++;
        end
        if (res_o.dispatch_task !== want.dispatch_task) begin
          $display("%0t: dispatch_task expected %0d, actual %0d", $time,
                   want.dispatch_task, res_o.dispatch_task);
          mismatch_count++;
        end
        if (res_o.system_time !== want.system_time) begin
          $display("%0t: system_time expected %0h, actual %0h", $time,
                   want.system_time, res_o.system_time);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    cmd_t c;
    int   pick;
    rst_ni    = 1'b0;
    start     = 1'b0;
    cmd_i     = '0;
    en_mask   = '0;
    pend_mask = '0;
    sys_time  = '0;
    idle_pct  = 32;

    // commands on disabled slots, then a small schedule that fires and completes
    add_row(OP_DISPATCH,    3'd0, 32'h0,        1'b0, 1'b1, STAT_OK,      32'd0);
    add_row(OP_DISABLE,     3'd3, 32'h0,        1'b0, 1'b1, STAT_NOT_EN,  32'd0);
    add_row(OP_SET_PENDING, 3'd0, 32'h1234_5678, 1'b1, 1'b1, STAT_NOT_EN, 32'd0);
    add_row(OP_SET_DELAY,   3'd1, 32'hFFFF_FFFF, 1'b0, 1'b1, STAT_NOT_EN, 32'd0);
    add_row(OP_SET_PERIOD,  3'd4, 32'h0000_0003, 1'b0, 1'b1, STAT_NOT_EN, 32'd0);
    add_row(OP_RESET_TIMER, 3'd6, 32'h0,        1'b0, 1'b1, STAT_NOT_EN,  32'd0);
    add_row(OP_COMPLETE,    3'd5, 32'h0,        1'b1, 1'b1, STAT_NOT_EN,  32'd0);
    add_row(OP_TICK,        3'd0, 32'h0,        1'b0, 1'b1, STAT_OK,      32'd1);
    add_row(OP_INIT,        3'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, STAT_OK,     32'd1);
    add_row(OP_INIT,        3'd0, 32'h0000_0001, 1'b0, 1'b1, STAT_ALREADY, 32'd1);
    add_row(OP_INIT,        3'd7, 32'h0,        1'b0, 1'b1, STAT_OK,      32'd1);
    add_row(OP_INIT,        3'd2, 32'h0000_0002, 1'b1, 1'b1, STAT_OK,     32'd1);
    add_row(OP_TICK,        3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1, STAT_OK,     32'd2);
    add_row(OP_SET_PENDING, 3'd7, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);
    add_row(OP_DISPATCH,    3'd0, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);
    add_row(OP_DISPATCH,    3'd0, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);
    add_row(OP_TICK,        3'd0, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);
    add_row(OP_SET_DELAY,   3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0, STAT_OK,     32'd0);
    add_row(OP_COMPLETE,    3'd2, 32'hDEAD_BEEF, 1'b0, 1'b0, STAT_OK,     32'd0);
    add_row(OP_SET_PERIOD,  3'd2, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);
    add_row(OP_RESET_TIMER, 3'd2, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);
    add_row(OP_COMPLETE,    3'd7, 32'h0,        1'b1, 1'b0, STAT_OK,      32'd0);
    add_row(OP_DISPATCH,    3'd0, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);
    add_row(OP_RESERVED,    3'd5, 32'hA5A5_A5A5, 1'b1, 1'b1, STAT_OK,     32'd3);
    add_row(OP_DISABLE,     3'd0, 32'h0,        1'b0, 1'b0, STAT_OK,      32'd0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (directed_rows[k]) send(directed_rows[k].cmd, directed_rows[k].typed,
                                    directed_rows[k].res);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 32 : (phase == 1) ? 66 : 0;
      repeat (RANDOM_ITEMS / 3) begin
        pick          = $urandom_range(99);
        c.task_req    = 3'($urandom_range(TASK_COUNT - 1));
        c.task_failed = ($urandom_range(3) == 0);
        // mostly short periods and delays so slots fire often
        c.value       = ($urandom_range(9) < 8) ? 32'($urandom_range(6)) : $urandom;
        if      (pick < 30) c.opcode = OP_TICK;
        else if (pick < 42) c.opcode = OP_INIT;
        else if (pick < 56) c.opcode = OP_DISPATCH;
        else if (pick < 66) c.opcode = OP_COMPLETE;
        else if (pick < 72) c.opcode = OP_SET_PENDING;
        else if (pick < 79) c.opcode = OP_SET_DELAY;
        else if (pick < 85) c.opcode = OP_SET_PERIOD;
        else if (pick < 90) c.opcode = OP_RESET_TIMER;
        else if (pick < 96) c.opcode = OP_DISABLE;
        else c.opcode = 4'($urandom_range(OP_RESERVED, OP_COMPLETE + 1));
        send(c, 1'b0, '0);
      end
    end

    @(negedge clk_i) start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3 * TASK_COUNT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
